[hdl/tmq_pkg.sv]
// shared types, codes and constants of the timed event queue
package tmq_pkg;

    localparam int DEFAULT_DEPTH   = 16;
    localparam int DEFAULT_ID_BITS = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int FIRE_W          = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W          = 32;

    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_REMOVE  = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;

    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_REMOVED = 3'd2;
    localparam logic [2:0] ST_FIRED   = 3'd3;
    localparam logic [2:0] ST_NONE    = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [TIME_W-1:0]  key;
    } cell_ctrl_t;

    typedef struct packed {
        logic [1:0]   cmd;
        logic [31:0]  event_time;
        logic [15:0]  event_id;
        logic [31:0]  time_step;
    } tmq_in_t;

    typedef struct packed {
        logic [2:0]   status;
        logic [15:0]  fired_id;
        logic [31:0]  fired_time;
        logic [4:0]   removed_count;
        logic         last;
    } tmq_out_t;

endpackage

[hdl/tmq_cell.sv]
// one queue cell: holds a due time and id, passes entries to its neighbors
module tmq_cell #(
    parameter int ID_BITS = 16
) (
    input  logic                      clk,
    input  tmq_pkg::cell_ctrl_t       ctrl,
    input  logic                      occ,
    input  logic [ID_BITS-1:0]        new_id,
    input  logic [tmq_pkg::TIME_W-1:0] left_time,
    input  logic [ID_BITS-1:0]        left_id,
    input  logic [tmq_pkg::TIME_W-1:0] right_time,
    input  logic [ID_BITS-1:0]        right_id,
    input  logic                      flag_in,
    output logic [tmq_pkg::TIME_W-1:0] due_time,
    output logic [ID_BITS-1:0]        id,
    output logic                      flag_out
);
    import tmq_pkg::*;

    logic [TIME_W-1:0]  time_reg, time_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic               keep;
    logic               match;

    always_comb
    begin
        keep      = occ && (time_reg <= ctrl.key);
        match     = occ && (time_reg == ctrl.key);
        time_next = time_reg;
        id_next   = id_reg;
        flag_out  = flag_in;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                // keepers form a prefix; the first non-keeper takes the new word
                flag_out = keep;
                if (!keep)
                begin
                    if (flag_in)
                    begin
                        time_next = ctrl.key;
                        id_next   = new_id;
                    end
                    else
                    begin
                        time_next = left_time;
                        id_next   = left_id;
                    end
                end
            end
            CELL_SHIFT:
            begin
                // from the first match (or the head on a pop) onward, pull from the right
                flag_out = flag_in || match;
                if (flag_in || match)
                begin
                    time_next = right_time;
                    id_next   = right_id;
                end
            end
            default:
            begin
                flag_out = flag_in;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        id_reg   <= id_next;
    end

    assign due_time = time_reg;
    assign id       = id_reg;

endmodule

[hdl/timed_event_queue.sv]
// top level of the timed event queue: command sequencer and chain of cells
//
//  channel | handshake              | word      | meaning
//  --------+------------------------+-----------+-------------------------------
//  command | cmd_valid / cmd_ready  | cmd_word  | add, remove at time, advance
//  result  | res_valid / res_ready  | res_word  | status, fired event, count
//
//  one command at a time; cmd_ready is high only while the sequencer is idle
//  add: latch, then one insert pass through the cell chain
//  remove: latch, then one matching entry squeezed out of the chain per cycle,
//  then the count word; advance: latch, time step, then one pop of the chain
//  head per cycle while the result side is free; a none word if nothing is due
//  a stalled result holds the sequencer; reset clears the entry count and time,
//  the cell contents are left as they are
module timed_event_queue #(
    parameter int QUEUE_DEPTH = tmq_pkg::DEFAULT_DEPTH,
    parameter int ID_BITS     = tmq_pkg::DEFAULT_ID_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  tmq_pkg::tmq_in_t   cmd_word,
    output logic               res_valid,
    input  logic               res_ready,
    output tmq_pkg::tmq_out_t  res_word
);
    import tmq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_REMOVE,
        S_ADV,
        S_FIRE
    } state_t;

    state_t             state_reg, state_next;
    logic [TIME_W-1:0]  key_reg, key_next;
    logic [ID_BITS-1:0] id_reg, id_next;
    logic [TIME_W-1:0]  step_reg, step_next;
    logic [TIME_W-1:0]  cur_time_reg, cur_time_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rm_cnt_reg, rm_cnt_next;
    logic [FIRE_W-1:0]  fire_cnt_reg, fire_cnt_next;
    logic               out_valid_reg, out_valid_next;
    tmq_out_t           out_word_reg, out_word_next;

    // chain wiring
    cell_ctrl_t         ctrl;
    logic               head_flag;
    logic               occ       [QUEUE_DEPTH];
    logic [TIME_W-1:0]  cell_time [QUEUE_DEPTH];
    logic [ID_BITS-1:0] cell_id   [QUEUE_DEPTH];
    logic               flag      [QUEUE_DEPTH+1];

    logic               out_free;
    logic [TIME_W:0]    adv_sum;
    logic               head_due;
    logic               next_due;
    logic               fire_last;
    logic [31:0]        id_wide;
    logic [31:0]        in_id_wide;
    logic [31:0]        rm_wide;
    logic [4:0]         rm_sat;

    assign flag[0] = head_flag;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        // occupancy comes from the entry count, the cells carry no valid bit
        assign occ[i] = (CNT_W'(i) < count_reg);

        tmq_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occ        (occ[i]),
            .new_id     (id_reg),
            .left_time  ((i == 0) ? key_reg : cell_time[(i == 0) ? 0 : i-1]),
            .left_id    ((i == 0) ? id_reg : cell_id[(i == 0) ? 0 : i-1]),
            .right_time (cell_time[(i == QUEUE_DEPTH-1) ? i : i+1]),
            .right_id   (cell_id[(i == QUEUE_DEPTH-1) ? i : i+1]),
            .flag_in    (flag[i]),
            .due_time   (cell_time[i]),
            .id         (cell_id[i]),
            .flag_out   (flag[i+1])
        );
    end

    assign out_free = !out_valid_reg || res_ready;

    always_comb
    begin
        in_id_wide = 32'(cmd_word.event_id);
        id_wide    = 32'(cell_id[0]);
        rm_wide    = 32'(rm_cnt_reg);
        rm_sat     = (rm_wide > 32'd31) ? 5'd31 : rm_wide[4:0];
        adv_sum    = {1'b0, cur_time_reg} + {1'b0, step_reg};
        head_due   = occ[0] && (cell_time[0] <= cur_time_reg);
        next_due   = occ[1] && (cell_time[1] <= cur_time_reg);
        // last fired word when the following entry is not due or the burst limit is hit
        fire_last  = !next_due || (fire_cnt_reg == FIRE_W'(MAX_RESULTS - 1));

        state_next     = state_reg;
        key_next       = key_reg;
        id_next        = id_reg;
        step_next      = step_reg;
        cur_time_next  = cur_time_reg;
        count_next     = count_reg;
        rm_cnt_next    = rm_cnt_reg;
        fire_cnt_next  = fire_cnt_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_word_next  = out_word_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.key       = key_reg;
        head_flag      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    key_next  = cmd_word.event_time;
                    id_next   = in_id_wide[ID_BITS-1:0];
                    step_next = cmd_word.time_step;
                    unique case (cmd_word.cmd)
                        CMD_ADD:     state_next = S_ADD;
                        CMD_REMOVE:
                        begin
                            state_next  = S_REMOVE;
                            rm_cnt_next = '0;
                        end
                        CMD_ADVANCE: state_next = S_ADV;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = '0;
                    out_word_next.last = 1'b1;
                    if (count_reg == CNT_W'(QUEUE_DEPTH))
                    begin
                        out_word_next.status = ST_FULL;
                    end
                    else
                    begin
                        out_word_next.status = ST_ADDED;
                        ctrl.op    = CELL_INSERT;
                        head_flag  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_REMOVE:
            begin
                ctrl.op   = CELL_SHIFT;
                head_flag = 1'b0;
                if (flag[QUEUE_DEPTH])
                begin
                    // a match was found and squeezed out this cycle
                    rm_cnt_next = rm_cnt_reg + 1'b1;
                    count_next  = count_reg - 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = '0;
                    out_word_next.status        = ST_REMOVED;
                    out_word_next.removed_count = rm_sat;
                    out_word_next.last          = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ADV:
            begin
                cur_time_next = adv_sum[TIME_W] ? '1 : adv_sum[TIME_W-1:0];
                fire_cnt_next = '0;
                state_next    = S_FIRE;
            end
            S_FIRE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = '0;
                    if (head_due)
                    begin
                        out_word_next.status     = ST_FIRED;
                        out_word_next.fired_id   = id_wide[15:0];
                        out_word_next.fired_time = cell_time[0];
                        out_word_next.last       = fire_last;
                        ctrl.op       = CELL_SHIFT;
                        head_flag     = 1'b1;
                        count_next    = count_reg - 1'b1;
                        fire_cnt_next = fire_cnt_reg + 1'b1;
                        if (fire_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        // only reached before the first fire of this advance
                        out_word_next.status = ST_NONE;
                        out_word_next.last   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_time_reg  <= '0;
            count_reg     <= '0;
            rm_cnt_reg    <= '0;
            fire_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
            key_reg       <= '0;
            id_reg        <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_time_reg  <= cur_time_next;
            count_reg     <= count_next;
            rm_cnt_reg    <= rm_cnt_next;
            fire_cnt_reg  <= fire_cnt_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
            key_reg       <= key_next;
            id_reg        <= id_next;
            step_reg      <= step_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res_word  = out_word_reg;

    // occupancy never goes past the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // a full add leaves the queue untouched
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD) && out_free && (count_reg == CNT_W'(QUEUE_DEPTH))
        |=> (count_reg == CNT_W'(QUEUE_DEPTH)) && (res_word.status == ST_FULL))
        else $error("full add changed the queue");

    // a fired word is never due after the current time
    a_fired_due: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_word.status == ST_FIRED)
        |-> res_word.fired_time <= cur_time_reg)
        else $error("fired event not yet due");

    // a burst never exceeds the result limit
    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= FIRE_W'(MAX_RESULTS))
        else $error("fire burst beyond limit");

    // the last word of a burst returns the sequencer to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIRE) && out_free && head_due && fire_last
        |=> (state_reg == S_IDLE) && res_word.last)
        else $error("burst did not end on last word");

endmodule

[sim/timed_event_queue_test.sv]
// testbench of the timed event queue: directed and random commands checked against a predictor
module timed_event_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tmq_pkg::*;

    localparam int         DEPTH        = DEFAULT_DEPTH;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_WORDS = 100;
    localparam int         IDLE_LIMIT   = 600;
    localparam int         HOLD_AFTER   = 70;
    localparam int         HOLD_CYCLES  = 120;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         MAX_REPORTS  = 10;

    // predicted event queue plus the result words still owed by the block
    class event_schedule;
        logic [31:0] due_time [DEPTH];
        logic [15:0] due_id [DEPTH];
        int          occupancy;
        logic [31:0] clock_now;
        tmq_out_t    awaited_words [$];
        int          mismatches;

        function new();
            occupancy  = 0;
            clock_now  = '0;
            mismatches = 0;
        endfunction

        function void await_word(logic [2:0] status, logic [15:0] id, logic [31:0] due,
                                 logic [4:0] count, logic is_last);
            tmq_out_t w;
            w.status        = status;
            w.fired_id      = id;
            w.fired_time    = due;
            w.removed_count = count;
            w.last          = is_last;
            awaited_words.insert(awaited_words.size(), w);
        endfunction

        function void take_command(tmq_in_t w);
            int          pos;
            int          kept;
            int          fired;
            int          i;
            logic [32:0] sum;
            case (w.cmd)
                CMD_ADD:
                begin
                    if (occupancy >= DEPTH)
                        await_word(ST_FULL, '0, '0, '0, 1'b1);
                    else
                    begin
                        // new event goes behind every equal or earlier one
                        pos = 0;
                        while (pos < occupancy && due_time[pos] <= w.event_time)
                            pos++;
                        for (i = occupancy; i > pos; i--)
                        begin
                            due_time[i] = due_time[i-1];
                            due_id[i]   = due_id[i-1];
                        end
                        due_time[pos] = w.event_time;
                        due_id[pos]   = w.event_id;
                        occupancy++;
                        await_word(ST_ADDED, '0, '0, '0, 1'b1);
                    end
                end
                CMD_REMOVE:
                begin
                    kept = 0;
                    for (i = 0; i < occupancy; i++)
                    begin
                        if (due_time[i] != w.event_time)
                        begin
                            due_time[kept] = due_time[i];
                            due_id[kept]   = due_id[i];
                            kept++;
                        end
                    end
                    await_word(ST_REMOVED, '0, '0, 5'(occupancy - kept), 1'b1);
                    occupancy = kept;
                end
                CMD_ADVANCE:
                begin
                    sum       = {1'b0, clock_now} + {1'b0, w.time_step};
                    clock_now = sum[32] ? '1 : sum[31:0];
                    fired = 0;
                    while (fired < occupancy && fired < MAX_RESULTS &&
                           due_time[fired] <= clock_now)
                        fired++;
                    if (fired == 0)
                        await_word(ST_NONE, '0, '0, '0, 1'b1);
                    for (i = 0; i < fired; i++)
                        await_word(ST_FIRED, due_id[i], due_time[i], '0, i == fired - 1);
                    for (i = 0; i + fired < occupancy; i++)
                    begin
                        due_time[i] = due_time[i+fired];
                        due_id[i]   = due_id[i+fired];
                    end
                    occupancy -= fired;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch in %s: expected %0h, got %0h", what, want, got);
        endfunction

        function void take_result(tmq_out_t got);
            tmq_out_t want;
            if (awaited_words.size() == 0)
            begin
                flag("status of unawaited word", '0, 32'(got.status));
                return;
            end
            want = awaited_words[0];
            awaited_words.delete(0);
            if (got.status !== want.status)
                flag("status", 32'(want.status), 32'(got.status));
            if (got.fired_id !== want.fired_id)
                flag("fired_id", 32'(want.fired_id), 32'(got.fired_id));
            if (got.fired_time !== want.fired_time)
                flag("fired_time", want.fired_time, got.fired_time);
            if (got.removed_count !== want.removed_count)
                flag("removed_count", 32'(want.removed_count), 32'(got.removed_count));
            if (got.last !== want.last)
                flag("last", 32'(want.last), 32'(got.last));
        endfunction

        function int outstanding();
            return awaited_words.size();
        endfunction

        function logic [31:0] pick_queued_time();
            return due_time[$urandom_range(0, occupancy - 1)];
        endfunction
    endclass

    // every input known from time zero
    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_ready;
    tmq_in_t  cmd_word  = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    tmq_out_t res_word;

    // while set, neither side idles
    bit steady = 1'b0;
    int quiet  = 0;

    event_schedule schedule = new();

    timed_event_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_word  (res_word)
    );

    // 2 ns clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic tmq_in_t command_word(logic [1:0] cmd, logic [31:0] due,
                                             logic [15:0] id, logic [31:0] step);
        tmq_in_t w;
        w.cmd        = cmd;
        w.event_time = due;
        w.event_id   = id;
        w.time_step  = step;
        return w;
    endfunction

    // mostly near-term events, often on shared times so removes and ties hit
    function automatic tmq_in_t random_command();
        tmq_in_t w;
        int      pick;
        pick = $urandom_range(0, 99);
        w = command_word(CMD_UNUSED, $urandom, 16'($urandom), $urandom);
        if (pick < 45)
        begin
            w.cmd = CMD_ADD;
            pick  = $urandom_range(0, 9);
            if (pick >= 1 && pick < 4)
                w.event_time = schedule.clock_now + 32'(8 * $urandom_range(0, 3));
            else if (pick >= 4)
                w.event_time = schedule.clock_now + 32'($urandom_range(0, 60));
        end
        else if (pick < 65)
        begin
            w.cmd = CMD_REMOVE;
            if (schedule.occupancy > 0 && $urandom_range(0, 4) != 0)
                w.event_time = schedule.pick_queued_time();
            else
                w.event_time = schedule.clock_now + 32'($urandom_range(0, 60));
        end
        else if (pick < 95)
        begin
            w.cmd       = CMD_ADVANCE;
            w.time_step = ($urandom_range(0, 9) == 0) ? '0 : 32'($urandom_range(1, 40));
        end
        return w;
    endfunction

    // offer one word after a random gap; valid only drops when a gap is taken
    task automatic send_word(input tmq_in_t w);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        schedule.take_command(w);
        @(negedge clk);
    endtask

    // main stimulus: reset, directed opening, random body, time saturation at the end
    initial
    begin : stimulus
        int      sent;
        int      i;
        tmq_in_t w;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue: advance with nothing due
        send_word(command_word(CMD_ADVANCE, '0, '0, '0));
        // ties at time 5 keep arrival order, time 3 jumps ahead of them
        send_word(command_word(CMD_ADD, 32'd5, 16'h0000, '0));
        send_word(command_word(CMD_ADD, 32'd5, 16'hFFFF, '0));
        send_word(command_word(CMD_ADD, 32'd3, 16'h1234, '0));
        // extreme due times
        send_word(command_word(CMD_ADD, '1, 16'hA5A5, '0));
        send_word(command_word(CMD_ADD, '0, 16'h5A5A, '0));
        // unused command must leave no trace
        send_word(command_word(CMD_UNUSED, '1, '1, '1));
        // fires the four early events in order, the far one stays
        send_word(command_word(CMD_ADVANCE, '0, '0, 32'd5));
        // fill to the brim on a few shared times, then one add too many
        for (i = 0; i < 15; i++)
            send_word(command_word(CMD_ADD, 32'(10 + (i % 4) * 3), 16'($urandom), '0));
        send_word(command_word(CMD_ADD, 32'd12, 16'hBEEF, '0));
        send_word(command_word(CMD_REMOVE, '1, '0, '0));
        // back to full, then one advance fires the whole queue
        send_word(command_word(CMD_ADD, 32'd25, 16'h0F0F, '0));
        send_word(command_word(CMD_ADVANCE, '0, '0, 32'd20));

        // random body, with a stretch where neither side idles
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            steady = (sent >= 40 && sent < 60);
            w = random_command();
            send_word(w);
            if (w.cmd != CMD_UNUSED)
                sent++;
        end
        steady = 1'b0;

        // large steps last, since a saturated clock makes every event due at once
        send_word(command_word(CMD_ADD, 32'hFFFF_FFFE, 16'($urandom), '0));
        send_word(command_word(CMD_ADVANCE, '0, '0, 32'h5555_5555));
        send_word(command_word(CMD_ADVANCE, '0, '0, 32'hAAAA_AAAA));
        send_word(command_word(CMD_ADD, '1, 16'($urandom), '0));
        send_word(command_word(CMD_ADVANCE, '0, '0, '1));
        cmd_valid <= 1'b0;

        // wait for every owed word, then a short tail for strays
        while (schedule.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (schedule.mismatches == 0 && schedule.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off that backs up the command side
    initial
    begin : drain
        int taken;
        int stall;
        bit held;
        taken = 0;
        held  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (!held && taken == HOLD_AFTER)
            begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
            schedule.take_result(res_word);
            taken++;
            @(negedge clk);
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
            quiet = 0;
        else if (quiet < IDLE_LIMIT)
            quiet = quiet + 1;
        else
        begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule

[files.f]
hdl/tmq_pkg.sv
hdl/tmq_cell.sv
hdl/timed_event_queue.sv
sim/timed_event_queue_test.sv
